// File: hdl/scd_pkg.sv
// ----------------------------------------------------------------------------
// Scene cut detector package
// Beat types, configuration codes, color coefficients and the small helper
// functions that the detector modules share.
// ----------------------------------------------------------------------------
package scd_pkg;

	// One pixel beat on the input channel.
	typedef struct packed {
		logic        frame_start;
		logic [15:0] pixel_index;
		logic [7:0]  luma;
		logic [7:0]  chroma_blue;
		logic [7:0]  chroma_red;
	} pixel_t;

	// One decision beat on the output channel.
	typedef struct packed {
		logic [31:0] frame_number;
		logic        scene_cut;
		logic        forced;
		logic [7:0]  mean_difference;
	} result_t;

	// Stored pixel, laid out as R in the top byte and B in the bottom byte.
	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	// Live configuration handed to the decision unit.
	typedef struct packed {
		logic [7:0]  threshold;
		logic [15:0] stop_frames;
		logic [15:0] min_frames;
	} cfg_t;

	// Snapshot of a finished frame that the decision unit works on.
	typedef struct packed {
		logic [25:0] sum;
		logic [17:0] count;
		logic [31:0] frame;
	} decide_req_t;

	// Decision unit sequencer states.
	typedef enum logic [2:0] {
		DEC_IDLE,
		DEC_SAT,
		DEC_DIV,
		DEC_DECIDE,
		DEC_OUT
	} dec_state_t;

	// Configuration register indexes.
	localparam logic [1:0] CFG_THRESHOLD   = 2'd0;
	localparam logic [1:0] CFG_STOP_FRAMES = 2'd1;
	localparam logic [1:0] CFG_MIN_FRAMES  = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [7:0]  THRESHOLD_RESET   = 8'd100;
	localparam logic [15:0] STOP_FRAMES_RESET = 16'd8;
	localparam logic [15:0] MIN_FRAMES_RESET  = 16'd250;

	// Q1.16 conversion coefficients.
	localparam logic [16:0] COEF_R_CR = 17'd91881;
	localparam logic [16:0] COEF_G_CB = 17'd22554;
	localparam logic [16:0] COEF_G_CR = 17'd46802;
	localparam logic [16:0] COEF_B_CB = 17'd116130;

	// Chroma offset and accumulator limits.
	localparam logic [7:0]  CHROMA_OFFSET = 8'd128;
	localparam logic [25:0] SUM_MAX       = 26'h3FFFFFF;
	localparam logic [17:0] COUNT_MAX     = 18'h3FFFF;
	localparam logic [17:0] COUNT_STEP    = 18'd3;

	// Clamp a signed intermediate color value to one byte.
	function automatic logic [7:0] clamp_byte(input logic signed [10:0] v);
		logic [7:0] res;
		if (v < 0) begin
			res = 8'd0;
		end else if (v > 11'sd255) begin
			res = 8'd255;
		end else begin
			res = v[7:0];
		end
		return res;
	endfunction

	// Absolute difference of two bytes.
	function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] res;
		if (a > b) begin
			res = a - b;
		end else begin
			res = b - a;
		end
		return res;
	endfunction

endpackage

// File: hdl/scd_ram.sv
// ----------------------------------------------------------------------------
// Scene cut detector RAM
// Generic single-write, single-read synchronous memory with a registered
// read port. A read that meets a write to the same entry returns old data.
// ----------------------------------------------------------------------------
module scd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; data holds while no read is enabled.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/scd_convert.sv
// ----------------------------------------------------------------------------
// Scene cut detector front end
// Two pipeline stages that turn a YCbCr beat into clamped RGB and reduce the
// pixel index to a frame store address.
// ----------------------------------------------------------------------------
module scd_convert import scd_pkg::*; #(
	parameter int FRAME_PIXELS = 65536
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            advance,
	input  logic                            beat_valid,
	input  pixel_t                          beat,
	output logic                            valid_s2,
	output logic                            frame_start_s2,
	output logic [$clog2(FRAME_PIXELS)-1:0] addr,
	output rgb_t                            rgb
);

	localparam int IDX_W    = $clog2(FRAME_PIXELS);
	localparam bit NEED_MOD = FRAME_PIXELS < 65536;
	localparam int MOD_D    = NEED_MOD ? FRAME_PIXELS : 65536;
	// Reciprocal that gives the exact quotient for any 16-bit index.
	localparam logic [32:0] RECIP = 33'((64'd1 << 32) / MOD_D + 64'd1);

	// Stage 1 registers: the accepted beat.
	logic   valid_s1;
	pixel_t pix_s1;

	// Stage 2 registers: scaled chroma terms and the index quotient.
	logic               frame_start_q2;
	logic [7:0]         luma_s2;
	logic signed [8:0]  pr_s2;
	logic signed [8:0]  pgb_s2;
	logic signed [8:0]  pgr_s2;
	logic signed [8:0]  pb_s2;
	logic [15:0]        index_s2;
	logic [15:0]        quot_s2;

	// Stage 1 combinational terms.
	logic              cb_neg;
	logic              cr_neg;
	logic [7:0]        cb_mag;
	logic [7:0]        cr_mag;
	logic [24:0]       prod_r;
	logic [24:0]       prod_gb;
	logic [24:0]       prod_gr;
	logic [24:0]       prod_b;
	logic [48:0]       prod_idx;
	logic signed [8:0] term_r;
	logic signed [8:0] term_gb;
	logic signed [8:0] term_gr;
	logic signed [8:0] term_b;

	// Stage 2 combinational terms.
	logic [32:0]        quot_prod;
	logic [15:0]        rem_idx;
	logic signed [10:0] luma_ext;
	logic signed [10:0] r_raw;
	logic signed [10:0] g_raw;
	logic signed [10:0] b_raw;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= beat_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pix_s1 <= beat;
		end
	end

	// Chroma magnitudes and the truncated coefficient products.
	always_comb begin
		cb_neg   = !pix_s1.chroma_blue[7];
		cr_neg   = !pix_s1.chroma_red[7];
		cb_mag   = cb_neg ? (CHROMA_OFFSET - pix_s1.chroma_blue)
		                  : (pix_s1.chroma_blue - CHROMA_OFFSET);
		cr_mag   = cr_neg ? (CHROMA_OFFSET - pix_s1.chroma_red)
		                  : (pix_s1.chroma_red - CHROMA_OFFSET);
		prod_r   = 25'(COEF_R_CR) * 25'(cr_mag);
		prod_gb  = 25'(COEF_G_CB) * 25'(cb_mag);
		prod_gr  = 25'(COEF_G_CR) * 25'(cr_mag);
		prod_b   = 25'(COEF_B_CB) * 25'(cb_mag);
		term_r   = cr_neg ? -$signed({1'b0, prod_r[23:16]}) : $signed({1'b0, prod_r[23:16]});
		term_gb  = cb_neg ? -$signed({1'b0, prod_gb[23:16]}) : $signed({1'b0, prod_gb[23:16]});
		term_gr  = cr_neg ? -$signed({1'b0, prod_gr[23:16]}) : $signed({1'b0, prod_gr[23:16]});
		term_b   = cb_neg ? -$signed({1'b0, prod_b[23:16]}) : $signed({1'b0, prod_b[23:16]});
		prod_idx = 49'(pix_s1.pixel_index) * 49'(RECIP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			frame_start_q2 <= pix_s1.frame_start;
			luma_s2        <= pix_s1.luma;
			pr_s2          <= term_r;
			pgb_s2         <= term_gb;
			pgr_s2         <= term_gr;
			pb_s2          <= term_b;
			index_s2       <= pix_s1.pixel_index;
			quot_s2        <= prod_idx[47:32];
		end
	end

	// Remainder of the index and the clamped color sums.
	always_comb begin
		quot_prod = 33'(quot_s2) * 33'(MOD_D);
		rem_idx   = index_s2 - quot_prod[15:0];
		if (NEED_MOD) begin
			addr = IDX_W'(rem_idx);
		end else begin
			addr = IDX_W'(index_s2);
		end
		luma_ext = $signed({3'b000, luma_s2});
		r_raw    = luma_ext + 11'(pr_s2);
		g_raw    = luma_ext - 11'(pgb_s2) - 11'(pgr_s2);
		b_raw    = luma_ext + 11'(pb_s2);
		rgb.r    = clamp_byte(r_raw);
		rgb.g    = clamp_byte(g_raw);
		rgb.b    = clamp_byte(b_raw);
	end

	assign frame_start_s2 = frame_start_q2;

endmodule

// File: hdl/scd_decide.sv
// ----------------------------------------------------------------------------
// Scene cut detector decision unit
// Divides a frame's difference sum by its sample count one quotient bit per
// cycle, applies the cut rules and holds the result beat until it is taken.
// ----------------------------------------------------------------------------
module scd_decide import scd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        launch,
	input  decide_req_t req,
	input  cfg_t        cfg,
	output logic        busy,
	output logic        result_valid,
	input  logic        result_stall,
	output result_t     result
);

	dec_state_t state_q;
	dec_state_t state_nx;

	logic [25:0] rem_q;
	logic [17:0] cnt_q;
	logic [31:0] frame_q;
	logic [7:0]  quo_q;
	logic [2:0]  step_q;
	logic [31:0] last_cut_q;
	logic        last_cut_valid_q;
	result_t     result_q;

	logic        cnt_zero;
	logic        sat_hit;
	logic [25:0] trial;
	logic        trial_fits;
	logic [31:0] frame_gap;
	logic        cut;
	logic        forced;

	// Divider compares and the cut rules.
	always_comb begin
		cnt_zero   = cnt_q == 18'd0;
		sat_hit    = rem_q >= {cnt_q, 8'd0};
		trial      = 26'(cnt_q) << step_q;
		trial_fits = rem_q >= trial;
		frame_gap  = frame_q - last_cut_q;
		cut        = cnt_zero || (quo_q >= cfg.threshold);
		forced     = cnt_zero;
		if (cut) begin
			if (last_cut_valid_q && (frame_gap < 32'(cfg.stop_frames))) begin
				cut = 1'b0;
			end
		end else if (!last_cut_valid_q || (frame_gap >= 32'(cfg.min_frames))) begin
			cut    = 1'b1;
			forced = 1'b1;
		end
		if (!cut) begin
			forced = 1'b0;
		end
	end

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			DEC_IDLE: begin
				if (launch) begin
					state_nx = DEC_SAT;
				end
			end
			DEC_SAT: begin
				if (cnt_zero || sat_hit) begin
					state_nx = DEC_DECIDE;
				end else begin
					state_nx = DEC_DIV;
				end
			end
			DEC_DIV: begin
				if (step_q == 3'd0) begin
					state_nx = DEC_DECIDE;
				end
			end
			DEC_DECIDE: begin
				state_nx = DEC_OUT;
			end
			DEC_OUT: begin
				if (!result_stall) begin
					state_nx = DEC_IDLE;
				end
			end
			default: begin
				state_nx = DEC_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		busy         = state_q != DEC_IDLE;
		result_valid = state_q == DEC_OUT;
		result       = result_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DEC_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Last cut tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_cut_q       <= 32'd0;
			last_cut_valid_q <= 1'b0;
		end else if (state_q == DEC_DECIDE && cut) begin
			last_cut_q       <= frame_q;
			last_cut_valid_q <= 1'b1;
		end
	end

	// Divider datapath and the result register.
	always_ff @(posedge clk) begin
		unique case (state_q)
			DEC_IDLE: begin
				if (launch) begin
					rem_q   <= req.sum;
					cnt_q   <= req.count;
					frame_q <= req.frame;
					quo_q   <= 8'd0;
					step_q  <= 3'd7;
				end
			end
			DEC_SAT: begin
				// A quotient of 256 or more saturates to the top code.
				if (!cnt_zero && sat_hit) begin
					quo_q <= 8'hFF;
				end
			end
			DEC_DIV: begin
				if (trial_fits) begin
					rem_q         <= rem_q - trial;
					quo_q[step_q] <= 1'b1;
				end
				step_q <= step_q - 3'd1;
			end
			DEC_DECIDE: begin
				result_q.frame_number    <= frame_q;
				result_q.scene_cut       <= cut;
				result_q.forced          <= forced;
				result_q.mean_difference <= quo_q;
			end
			DEC_OUT: begin
			end
			default: begin
			end
		endcase
	end

endmodule

// File: hdl/scene_cut_detector_unit.sv
// ----------------------------------------------------------------------------
// Scene cut detector
// Converts a YCbCr pixel stream to RGB, sums absolute differences against
// the previous frame held in a frame store, and reports one decision beat
// per completed frame.
//
//   Channel  Signals                           Direction  Beat
//   pixel    pixel_valid, pixel_stall, pixel   in         pixel_t
//   result   result_valid, result_stall, ...   out        result_t
//   cfg      cfg_valid, cfg_ready, cfg_index,  in         register write
//            cfg_data
//
// A pixel is taken every cycle while pixel_stall is low and writes the frame store
// from the store stage. A frame-start pixel that closes a frame needs the decision
// unit, which stays busy from launch until its result beat is taken; a further
// frame-start pixel reaching the store stage waits for it.
// Reset clears control state only; the frame store is undefined until written.
// A stall on the result channel holds the pipeline only through that wait.
// ----------------------------------------------------------------------------
module scene_cut_detector_unit import scd_pkg::*; #(
	parameter int FRAME_PIXELS = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pixel_valid,
	output logic        pixel_stall,
	input  pixel_t      pixel,
	output logic        result_valid,
	input  logic        result_stall,
	output result_t     result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int IDX_W = $clog2(FRAME_PIXELS);

	cfg_t cfg_q;

	logic             advance;
	logic             valid_s2;
	logic             frame_start_s2;
	logic [IDX_W-1:0] addr_s2;
	rgb_t             rgb_s2;

	// Store stage registers.
	logic             valid_s3;
	logic             frame_start_s3;
	logic [IDX_W-1:0] addr_s3;
	rgb_t             rgb_s3;
	logic             fwd_s3;
	rgb_t             fwd_rgb_s3;
	logic [23:0]      rdata;

	// Frame accumulation state.
	logic [25:0] sum_q;
	logic [17:0] count_q;
	logic [31:0] frame_q;
	logic        seen_q;

	logic        busy;
	logic        launch;
	decide_req_t req;

	rgb_t        prev;
	logic [9:0]  diff;
	logic [31:0] frame_nx;
	logic        seen_nx;
	logic [25:0] sum_base;
	logic [17:0] count_base;
	logic        compare;
	logic [26:0] sum_add;
	logic [18:0] count_add;
	logic [25:0] sum_nx;
	logic [17:0] count_nx;

	// Configuration registers; a write lands in any cycle, so the writer
	// keeps writes to times when no frame is in flight.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold   <= THRESHOLD_RESET;
			cfg_q.stop_frames <= STOP_FRAMES_RESET;
			cfg_q.min_frames  <= MIN_FRAMES_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_THRESHOLD:   cfg_q.threshold   <= cfg_data[7:0];
				CFG_STOP_FRAMES: cfg_q.stop_frames <= cfg_data;
				CFG_MIN_FRAMES:  cfg_q.min_frames  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// The whole pipeline moves together unless a frame close must wait.
	assign advance     = !(valid_s3 && frame_start_s3 && seen_q && busy);
	assign pixel_stall = !advance;

	scd_convert #(
		.FRAME_PIXELS(FRAME_PIXELS)
	) u_convert (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.beat_valid    (pixel_valid),
		.beat          (pixel),
		.valid_s2      (valid_s2),
		.frame_start_s2(frame_start_s2),
		.addr          (addr_s2),
		.rgb           (rgb_s2)
	);

	// Frame store of the previous frame's RGB.
	scd_ram #(
		.WIDTH(24),
		.DEPTH(FRAME_PIXELS)
	) u_store (
		.clk  (clk),
		.we   (advance && valid_s3),
		.waddr(addr_s3),
		.wdata(rgb_s3),
		.re   (advance),
		.raddr(addr_s2),
		.rdata(rdata)
	);

	// Store stage; a read that met the write of the same entry is forwarded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			frame_start_s3 <= frame_start_s2;
			addr_s3        <= addr_s2;
			rgb_s3         <= rgb_s2;
			fwd_s3         <= valid_s3 && (addr_s3 == addr_s2);
			fwd_rgb_s3     <= rgb_s3;
		end
	end

	// Difference against the stored pixel and the saturating accumulators.
	always_comb begin
		prev       = fwd_s3 ? fwd_rgb_s3 : rgb_t'(rdata);
		diff       = 10'(abs_diff(prev.r, rgb_s3.r)) + 10'(abs_diff(prev.g, rgb_s3.g))
		             + 10'(abs_diff(prev.b, rgb_s3.b));
		frame_nx   = frame_start_s3 ? (frame_q + 32'd1) : frame_q;
		seen_nx    = frame_start_s3 || seen_q;
		sum_base   = frame_start_s3 ? 26'd0 : sum_q;
		count_base = frame_start_s3 ? 18'd0 : count_q;
		compare    = seen_nx && (frame_nx != 32'd0);
		sum_add    = 27'(sum_base) + 27'(diff);
		count_add  = 19'(count_base) + 19'(COUNT_STEP);
		sum_nx     = sum_base;
		count_nx   = count_base;
		if (compare) begin
			sum_nx   = (sum_add > 27'(SUM_MAX)) ? SUM_MAX : sum_add[25:0];
			count_nx = (count_add > 19'(COUNT_MAX)) ? COUNT_MAX : count_add[17:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= 26'd0;
			count_q <= 18'd0;
			frame_q <= 32'hFFFFFFFF;
			seen_q  <= 1'b0;
		end else if (advance && valid_s3) begin
			sum_q   <= sum_nx;
			count_q <= count_nx;
			frame_q <= frame_nx;
			seen_q  <= seen_nx;
		end
	end

	// Close the open frame at a frame-start pixel.
	always_comb begin
		launch    = advance && valid_s3 && frame_start_s3 && seen_q;
		req.sum   = sum_q;
		req.count = count_q;
		req.frame = frame_q;
	end

	scd_decide u_decide (
		.clk         (clk),
		.arst_n      (arst_n),
		.launch      (launch),
		.req         (req),
		.cfg         (cfg_q),
		.busy        (busy),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

endmodule
